[rtl/speed_accel_observer_macros.svh]
// Assertion shorthands for the observer, clocked on clk, quiet during reset.
`ifndef SPEED_ACCEL_OBSERVER_MACROS_SVH
`define SPEED_ACCEL_OBSERVER_MACROS_SVH

// Same-cycle implication.
`define SOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/soa_pkg.sv]
`default_nettype none

package soa_pkg;

    // Field widths of the channels
    localparam int POSITION_W = 24;
    localparam int SPEED_OUT_W = 28;
    localparam int ACCEL_OUT_W = 32;

    // Configuration of the observer
    localparam int SPEED_TAPS = 8;
    localparam int ACCEL_TAPS = 8;
    localparam int POSITION_BITS = 24;

    // Derived internal widths, exact sums
    localparam int DIFF_W = POSITION_BITS + 1;
    localparam int SPEED_SUM_W = DIFF_W + $clog2(SPEED_TAPS);
    localparam int SDIFF_W = SPEED_SUM_W + 1;
    localparam int ACCEL_SUM_W = SDIFF_W + $clog2(ACCEL_TAPS);
    localparam int DSLOT_W = $clog2(SPEED_TAPS);
    localparam int ASLOT_W = $clog2(ACCEL_TAPS);

    // Result queue: holds every transaction in flight and every result not yet taken
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW = $clog2(RQ_DEPTH);
    localparam int RQ_CW = $clog2(RQ_DEPTH + 1) + 1;

    typedef logic signed [POSITION_W-1:0] position_t;
    typedef logic signed [SPEED_OUT_W-1:0] speed_out_t;
    typedef logic signed [ACCEL_OUT_W-1:0] accel_out_t;

    typedef struct packed {
        speed_out_t speed_x8;
        accel_out_t accel_x64;
    } result_t;

endpackage

`default_nettype wire

[rtl/soa_if.sv]
`default_nettype none

interface soa_sample_if;
    logic valid;
    logic ready;
    soa_pkg::position_t position;

    modport source (output valid, output position, input ready);
    modport sink (input valid, input position, output ready);
endinterface

interface soa_result_if;
    logic valid;
    logic ready;
    soa_pkg::speed_out_t speed_x8;
    soa_pkg::accel_out_t accel_x64;

    modport source (output valid, output speed_x8, output accel_x64, input ready);
    modport sink (input valid, input speed_x8, input accel_x64, output ready);
endinterface

`default_nettype wire

[rtl/speed_accel_observer.sv]
// Speed and acceleration observer. Each position transaction yields one result:
// speed_x8, the sum of the last eight position differences, and accel_x64, the
// sum of the last eight differences of that speed; both exact, no rounding. The
// first transaction after reset only primes the block and returns zeros. One
// transaction is taken every cycle while the result queue has room; its result
// is built in registered steps: the taking edge reads the difference ring, then
// the speed is updated, then the acceleration is updated and the result queue
// written, after which it is valid. The rate rests on the read-modify-write of
// each difference ring and its running sum. The rings sit in small synchronous
// RAMs, cleared at reset through per-entry valid bits; no clearing pass is needed.
// A four-entry result queue lets positions keep flowing while the consumer stalls.
`default_nettype none
`include "speed_accel_observer_macros.svh"

module speed_accel_observer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    soa_sample_if.sink         sample,
    soa_result_if.source       result
);

    typedef logic signed [soa_pkg::POSITION_BITS-1:0] pos_t;
    typedef logic signed [soa_pkg::DIFF_W-1:0] diff_t;
    typedef logic signed [soa_pkg::SPEED_SUM_W-1:0] speed_t;
    typedef logic signed [soa_pkg::SDIFF_W-1:0] sdiff_t;
    typedef logic signed [soa_pkg::ACCEL_SUM_W-1:0] accel_t;

    // Ring memories and their valid bits
    diff_t  diff_mem [soa_pkg::SPEED_TAPS];
    sdiff_t sdiff_mem [soa_pkg::ACCEL_TAPS];
    logic [soa_pkg::SPEED_TAPS-1:0] diff_vld_reg;
    logic [soa_pkg::ACCEL_TAPS-1:0] sdiff_vld_reg;

    // Control state
    logic                        primed_reg;
    logic [soa_pkg::DSLOT_W-1:0] dslot_reg, dslot_next;
    logic [soa_pkg::ASLOT_W-1:0] aslot_reg, aslot_next;
    pos_t                        last_pos_reg;
    speed_t                      speed_sum_reg;
    speed_t                      last_speed_reg;
    accel_t                      accel_sum_reg;

    // Stage 1: position taken, diff ring read in flight
    logic                        s1_valid_reg;
    logic                        s1_prime_reg;
    pos_t                        s1_pos_reg;
    logic [soa_pkg::DSLOT_W-1:0] s1_dslot_reg;
    logic [soa_pkg::ASLOT_W-1:0] s1_aslot_reg;
    diff_t                       diff_old_reg;
    logic                        diff_old_vld_reg;

    // Stage 2: speed known, speed-diff ring read in flight
    logic                        s2_valid_reg;
    logic                        s2_prime_reg;
    speed_t                      s2_speed_reg;
    logic [soa_pkg::ASLOT_W-1:0] s2_aslot_reg;
    sdiff_t                      sdiff_old_reg;
    logic                        sdiff_old_vld_reg;

    // Result queue
    soa_pkg::result_t          rq_mem [soa_pkg::RQ_DEPTH];
    logic [soa_pkg::RQ_AW-1:0] rq_wr_reg, rq_rd_reg;
    logic [soa_pkg::RQ_CW-1:0] rq_cnt_reg, rq_cnt_next;
    logic [soa_pkg::RQ_CW-1:0] occupancy;

    logic   take;
    logic   give;
    pos_t   pos_in;
    diff_t  d;
    diff_t  diff_old;
    speed_t speed_new;
    sdiff_t sd;
    sdiff_t sdiff_old;
    accel_t accel_new;
    soa_pkg::result_t rq_in;

    // ---------------------------------------------------------------- handshake
    assign occupancy = rq_cnt_reg + soa_pkg::RQ_CW'(s1_valid_reg)
                       + soa_pkg::RQ_CW'(s2_valid_reg);
    assign sample.ready = occupancy < soa_pkg::RQ_CW'(soa_pkg::RQ_DEPTH);
    assign take = sample.valid && sample.ready;

    assign result.valid = rq_cnt_reg != '0;
    assign give = result.valid && result.ready;
    assign result.speed_x8 = rq_mem[rq_rd_reg].speed_x8;
    assign result.accel_x64 = rq_mem[rq_rd_reg].accel_x64;

    assign pos_in = $signed(sample.position[soa_pkg::POSITION_BITS-1:0]);

    // ------------------------------------------------------------ slot counters
    always_comb
    begin
        dslot_next = dslot_reg;
        aslot_next = aslot_reg;
        // the priming transaction writes neither ring
        if (take && primed_reg)
        begin
            if (dslot_reg == soa_pkg::DSLOT_W'(soa_pkg::SPEED_TAPS - 1))
            begin
                dslot_next = '0;
            end
            else
            begin
                dslot_next = dslot_reg + 1'b1;
            end
            if (aslot_reg == soa_pkg::ASLOT_W'(soa_pkg::ACCEL_TAPS - 1))
            begin
                aslot_next = '0;
            end
            else
            begin
                aslot_next = aslot_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------- stage 1 datapath
    assign d = soa_pkg::DIFF_W'(s1_pos_reg) - soa_pkg::DIFF_W'(last_pos_reg);
    assign diff_old = diff_old_vld_reg ? diff_old_reg : '0;
    assign speed_new = s1_prime_reg ? '0 :
                       speed_sum_reg + soa_pkg::SPEED_SUM_W'(d)
                       - soa_pkg::SPEED_SUM_W'(diff_old);

    // ------------------------------------------------------- stage 2 datapath
    assign sd = soa_pkg::SDIFF_W'(s2_speed_reg) - soa_pkg::SDIFF_W'(last_speed_reg);
    assign sdiff_old = sdiff_old_vld_reg ? sdiff_old_reg : '0;
    assign accel_new = s2_prime_reg ? '0 :
                       accel_sum_reg + soa_pkg::ACCEL_SUM_W'(sd)
                       - soa_pkg::ACCEL_SUM_W'(sdiff_old);

    assign rq_in.speed_x8 = soa_pkg::SPEED_OUT_W'(s2_speed_reg);
    assign rq_in.accel_x64 = soa_pkg::ACCEL_OUT_W'(accel_new);

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (s2_valid_reg && !give)
        begin
            rq_cnt_next = rq_cnt_reg + 1'b1;
        end
        else if (!s2_valid_reg && give)
        begin
            rq_cnt_next = rq_cnt_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------ memories
    // The write of one transaction and the read for the next always hit
    // neighboring slots, so no forwarding is required.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            diff_old_reg <= diff_mem[dslot_reg];
        end
        if (s1_valid_reg && !s1_prime_reg)
        begin
            diff_mem[s1_dslot_reg] <= d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            sdiff_old_reg <= sdiff_mem[s1_aslot_reg];
        end
        if (s2_valid_reg && !s2_prime_reg)
        begin
            sdiff_mem[s2_aslot_reg] <= sd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            rq_mem[rq_wr_reg] <= rq_in;
        end
    end

    // ------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pos_reg <= pos_in;
            s1_dslot_reg <= dslot_reg;
            s1_aslot_reg <= aslot_reg;
        end
        if (s1_valid_reg)
        begin
            s2_speed_reg <= speed_new;
            s2_aslot_reg <= s1_aslot_reg;
        end
    end

    // ------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            dslot_reg <= '0;
            aslot_reg <= '0;
            diff_vld_reg <= '0;
            sdiff_vld_reg <= '0;
            diff_old_vld_reg <= 1'b0;
            sdiff_old_vld_reg <= 1'b0;
            last_pos_reg <= '0;
            speed_sum_reg <= '0;
            last_speed_reg <= '0;
            accel_sum_reg <= '0;
            s1_valid_reg <= 1'b0;
            s1_prime_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_prime_reg <= 1'b0;
            rq_wr_reg <= '0;
            rq_rd_reg <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            dslot_reg <= dslot_next;
            aslot_reg <= aslot_next;
            rq_cnt_reg <= rq_cnt_next;
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;

            if (take)
            begin
                primed_reg <= 1'b1;
                s1_prime_reg <= !primed_reg;
                diff_old_vld_reg <= diff_vld_reg[dslot_reg];
            end

            if (s1_valid_reg)
            begin
                last_pos_reg <= s1_pos_reg;
                s2_prime_reg <= s1_prime_reg;
                sdiff_old_vld_reg <= sdiff_vld_reg[s1_aslot_reg];
                if (!s1_prime_reg)
                begin
                    diff_vld_reg[s1_dslot_reg] <= 1'b1;
                    speed_sum_reg <= speed_new;
                end
            end

            if (s2_valid_reg)
            begin
                last_speed_reg <= s2_speed_reg;
                rq_wr_reg <= rq_wr_reg + 1'b1;
                if (!s2_prime_reg)
                begin
                    sdiff_vld_reg[s2_aslot_reg] <= 1'b1;
                    accel_sum_reg <= accel_new;
                end
            end

            if (give)
            begin
                rq_rd_reg <= rq_rd_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------ assertions
    `SOA_ASSERT_NOW(a_diff_no_collide,
        take && s1_valid_reg && !s1_prime_reg, dslot_reg != s1_dslot_reg,
        "diff ring read and write hit the same slot")
    `SOA_ASSERT_NOW(a_sdiff_no_collide,
        s1_valid_reg && s2_valid_reg && !s2_prime_reg, s1_aslot_reg != s2_aslot_reg,
        "speed-diff ring read and write hit the same slot")
    `SOA_ASSERT_NOW(a_queue_room,
        s2_valid_reg, (rq_cnt_reg < soa_pkg::RQ_CW'(soa_pkg::RQ_DEPTH)) || give,
        "result queue overflow")
    `SOA_ASSERT_NEXT(a_prime_zero,
        s1_valid_reg && s1_prime_reg, s2_speed_reg == '0 && accel_new == '0,
        "priming transaction gave a nonzero result")
    `SOA_ASSERT_NOW(a_prime_once,
        s1_valid_reg && s1_prime_reg, !(s2_valid_reg && s2_prime_reg),
        "two priming transactions in flight")

endmodule

`default_nettype wire
